FILE: rtl/bpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared widths, operation and status codes, control structs and the
// first-free-bit encoder for one 64-bit bitmap word.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // Field and word widths.
    localparam int OP_W         = 2;
    localparam int PAGE_W       = 10;
    localparam int STATUS_W     = 2;
    localparam int WORD_W       = 64;
    localparam int BIT_IDX_W    = 6;
    // Only the first sixteen words hold pages that fit in a 10-bit page number.
    localparam int MAX_SEARCH_WORDS = 16;

    // Word 0 after reset or format: page 0 reserved.
    localparam logic [WORD_W-1:0] RESERVED_WORD = {1'b1, {(WORD_W-1){1'b0}}};

    // Request codes; the fourth code is unused and does nothing.
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_FORMAT = 2'd2
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // request accepted this cycle
        logic read;     // read the selected bitmap word
        logic update;   // write the modified word back
        logic finish;   // load the result word and raise the strobe
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rmw;      // the request needs a read-modify-write of the bitmap
    } t_dp_stat;

    // Index, counted from the MSB, of the first zero bit of a word that is
    // not all ones. Searched as eight groups of eight bits.
    function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [WORD_W-1:0] word);
        logic [7:0] grp_open;
        logic [2:0] grp;
        logic [7:0] sel_bits;
        logic [2:0] pos;
        grp = '0;
        pos = '0;
        for (int i = 0; i < 8; i++) begin
            grp_open[i] = ~&word[WORD_W-1-8*i -: 8];
        end
        for (int i = 7; i >= 0; i--) begin
            if (grp_open[i]) begin
                grp = 3'(i);
            end
        end
        sel_bits = word[{~grp, 3'b000} +: 8];
        for (int i = 7; i >= 0; i--) begin
            if (!sel_bits[7-i]) begin
                pos = 3'(i);
            end
        end
        return {grp, pos};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bpa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap page allocator controller
// Sequences each request: accept, then, for requests that touch the bitmap,
// bitmap word read and word update.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPDATE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    // Commands follow directly from the state and the start request.
    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && start;
        o_cmd.read    = (r_state == S_READ);
        o_cmd.update  = (r_state == S_UPDATE);
        o_cmd.finish  = (o_cmd.capture && !i_stat.rmw) || o_cmd.update;
    end

    // Next state: only requests that touch the bitmap word leave idle.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.capture && i_stat.rmw) begin
                    n_state = S_READ;
                end
            end
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    // State and registered busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

    // Busy is high exactly while a bitmap update is under way.
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy == (r_state != S_IDLE))
        else $error("busy does not track the controller state");

    // A read is always followed by the update.
    a_read_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.read |=> o_cmd.update)
        else $error("read not followed by update");

    // A request that needs the bitmap word makes the block busy.
    a_rmw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.capture && i_stat.rmw) |=> busy)
        else $error("read-modify-write request did not raise busy");

endmodule
`default_nettype wire

FILE: rtl/bpa_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap page allocator datapath
// Holds the bitmap memory, word valid and word-full flags, the request
// registers, the first-free encoder and the result register.
// ----------------------------------------------------------------------------
module bpa_dp
    import bpa_pkg::*;
#(
    parameter int BITMAP_WORDS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [PAGE_W-1:0] i_page_number,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    output logic                   o_done,
    output logic [PAGE_W-1:0]      o_granted_page,
    output logic [STATUS_W-1:0]    o_status
);

    // Words past the sixteenth can never be granted or freed in range.
    localparam int SEARCH_WORDS =
        (BITMAP_WORDS < MAX_SEARCH_WORDS) ? BITMAP_WORDS : MAX_SEARCH_WORDS;
    localparam int ADDR_W     = (SEARCH_WORDS > 1) ? $clog2(SEARCH_WORDS) : 1;
    localparam int PAGE_LIMIT = WORD_W * BITMAP_WORDS;

    logic [WORD_W-1:0]     mem [SEARCH_WORDS];
    logic [SEARCH_WORDS-1:0] r_vld;
    logic [SEARCH_WORDS-1:0] r_full;

    logic [OP_W-1:0]       r_op;
    logic [ADDR_W-1:0]     r_addr;
    logic [BIT_IDX_W-1:0]  r_bit;
    logic [WORD_W-1:0]     r_rdata;

    logic                  r_done;
    logic [PAGE_W-1:0]     r_granted;
    logic [STATUS_W-1:0]   r_status;

    logic                  w_any_open;
    logic [ADDR_W-1:0]     w_open_idx;
    logic                  w_in_range;
    logic [ADDR_W-1:0]     w_req_addr;
    logic [WORD_W-1:0]     w_cur_word;
    logic [BIT_IDX_W-1:0]  w_free_bit;
    logic [WORD_W-1:0]     w_new_word;
    logic                  w_is_alloc;

    // Lowest word with a free page, from the word-full flags.
    always_comb begin
        w_any_open = ~&r_full;
        w_open_idx = '0;
        for (int i = SEARCH_WORDS - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                w_open_idx = ADDR_W'(i);
            end
        end
    end

    // Request decode at accept time.
    always_comb begin
        w_in_range = (32'(i_page_number) < PAGE_LIMIT);
        case (i_operation)
            OP_ALLOC: begin
                o_stat.rmw = w_any_open;
                w_req_addr = w_open_idx;
            end
            OP_FREE: begin
                o_stat.rmw = w_in_range;
                w_req_addr = i_page_number[BIT_IDX_W +: ADDR_W];
            end
            default: begin
                o_stat.rmw = 1'b0;
                w_req_addr = w_open_idx;
            end
        endcase
    end

    // Word modification: set the first free bit or clear the freed one.
    always_comb begin
        w_is_alloc = (r_op == OP_ALLOC);
        if (r_vld[r_addr]) begin
            w_cur_word = r_rdata;
        end else begin
            w_cur_word = (r_addr == '0) ? RESERVED_WORD : '0;
        end
        w_free_bit = first_zero(w_cur_word);
        if (w_is_alloc) begin
            w_new_word = w_cur_word | (RESERVED_WORD >> w_free_bit);
        end else begin
            w_new_word = w_cur_word & ~(RESERVED_WORD >> r_bit);
        end
    end

    // Request registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_addr <= w_req_addr;
            r_bit  <= i_page_number[BIT_IDX_W-1:0];
        end
    end

    // Bitmap memory: one registered read, one write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rdata <= mem[r_addr];
        end
        if (i_cmd.update) begin
            mem[r_addr] <= w_new_word;
        end
    end

    // Word valid and word-full flags; a format clears them all at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_full <= '0;
        end else if (i_cmd.capture && i_operation == OP_FORMAT) begin
            r_vld  <= '0;
            r_full <= '0;
        end else if (i_cmd.update) begin
            r_vld[r_addr]  <= 1'b1;
            r_full[r_addr] <= w_is_alloc && (&w_new_word);
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    // Result word: immediate results at accept, the rest after the update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (i_cmd.update) begin
                r_granted <= w_is_alloc ? PAGE_W'({r_addr, w_free_bit}) : '0;
                r_status  <= ST_OK;
            end else begin
                r_granted <= '0;
                case (i_operation)
                    OP_ALLOC: r_status <= ST_FULL;
                    OP_FREE:  r_status <= ST_RANGE;
                    default:  r_status <= ST_OK;
                endcase
            end
        end
    end

    assign o_done         = r_done;
    assign o_granted_page = r_granted;
    assign o_status       = r_status;

    // A failed request never carries a page number.
    a_no_page_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_granted_page == '0))
        else $error("page number given with an error status");

    // A format leaves no word marked full or written.
    a_format_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.capture && i_operation == OP_FORMAT) |=> (r_full == '0 && r_vld == '0))
        else $error("format did not clear the word flags");

    // Every update produces a result strobe in the next cycle.
    a_update_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> o_done)
        else $error("update without result strobe");

endmodule
`default_nettype wire

FILE: rtl/bitmap_page_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit page allocator over a bitmap of 64-bit words, one bit per page.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Allocate and
// in-range free requests go through a read and an update of one bitmap word
// and keep busy high through the read and the update that follow the accept.
// Format, out-of-range free, allocate with no free page and the unused code
// finish in the accept cycle and leave busy low. Every request gives exactly
// one result word, shown for one cycle with o_done the cycle after its work
// ends; the receiver cannot stall it and must take it then. The lowest free
// word is picked from one full flag per word, so no scan of the bitmap is
// made; only the first sixteen words can hold a page that a 10-bit page
// number reaches.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int BITMAP_WORDS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [PAGE_W-1:0] i_page_number,
    output logic                   o_done,
    output logic [PAGE_W-1:0]      o_granted_page,
    output logic [STATUS_W-1:0]    o_status
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Request sequencing.
    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Bitmap storage and result generation.
    bpa_dp #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_operation    (i_operation),
        .i_page_number  (i_page_number),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_done         (o_done),
        .o_granted_page (o_granted_page),
        .o_status       (o_status)
    );

endmodule
`default_nettype wire

FILE: tb/tb_bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Sends allocate, free, format and unused-code words in random bursts. Each
// word is predicted against a private copy of the page bitmap when it is
// accepted. Each result strobe is checked against the oldest prediction. One
// sequence fills the first bitmap words so that the word-full flags are used.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator;
    import bpa_pkg::*;

    localparam int BITMAP_WORDS = 16;
    localparam int PAGE_MAX     = (1 << PAGE_W) - 1;
    localparam int RANDOM_WORDS = 650;
    localparam int CYCLE_LIMIT  = 200000;
    // The fourth request code has no name in the package.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [PAGE_W-1:0] page;
        bit                drain;   // hold this word back until all results are in
    } t_page_req;

    typedef struct {
        logic [PAGE_W-1:0] page;
        t_status           status;
    } t_page_grant;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_operation = '0;
    logic [PAGE_W-1:0]   i_page_number = '0;
    logic                o_done;
    logic [PAGE_W-1:0]   o_granted_page;
    logic [STATUS_W-1:0] o_status;

    t_page_req   request_q[$];
    t_page_grant grant_expect_q[$];
    logic [WORD_W-1:0] page_map [BITMAP_WORDS];

    int  mismatch_count = 0;
    int  words_accepted = 0;
    int  words_queued   = -1;
    int  stim_count     = 0;
    int  cycle_count    = 0;
    int  gap_left       = 0;
    int  burst_left     = 1;
    bit  word_taken     = 1'b0;

    bitmap_page_allocator #(
        .BITMAP_WORDS(BITMAP_WORDS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_page_number  (i_page_number),
        .o_done         (o_done),
        .o_granted_page (o_granted_page),
        .o_status       (o_status)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Every page free except page zero.
    function automatic void clear_page_map();
        for (int w = 0; w < BITMAP_WORDS; w++) begin
            page_map[w] = '0;
        end
        page_map[0] = RESERVED_WORD;
    endfunction

    // Works out the result of one request and updates the bitmap copy.
    function automatic t_page_grant predict_page_request(input t_page_req rq);
        t_page_grant g;
        int          k;
        int          pg;
        bit          searched;
        g.page   = '0;
        g.status = ST_OK;
        searched = 1'b0;
        case (rq.op)
            OP_ALLOC: begin
                g.status = ST_FULL;
                for (int w = 0; w < BITMAP_WORDS; w++) begin
                    // The first word with a free bit decides; a page beyond the
                    // reportable range counts as no page at all.
                    if (!searched && page_map[w] != {WORD_W{1'b1}}) begin
                        searched = 1'b1;
                        k = 0;
                        while (page_map[w][WORD_W-1-k]) begin
                            k++;
                        end
                        pg = w * WORD_W + k;
                        if (pg <= PAGE_MAX) begin
                            page_map[w][WORD_W-1-k] = 1'b1;
                            g.page   = pg[PAGE_W-1:0];
                            g.status = ST_OK;
                        end
                    end
                end
            end
            OP_FREE: begin
                pg = int'(rq.page);
                if (pg >= BITMAP_WORDS * WORD_W) begin
                    g.status = ST_RANGE;
                end else begin
                    page_map[pg / WORD_W][WORD_W-1-(pg % WORD_W)] = 1'b0;
                end
            end
            OP_FORMAT: begin
                clear_page_map();
            end
            default: begin
            end
        endcase
        return g;
    endfunction

    // Queues one request word; unused-code words do not count as stimulus.
    task automatic add_req(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page,
                           input bit drain);
        t_page_req rq;
        rq.op    = op;
        rq.page  = page;
        rq.drain = drain;
        request_q.push_back(rq);
        if (op != OP_UNUSED) begin
            stim_count++;
        end
    endtask

    function automatic logic [PAGE_W-1:0] any_page();
        return PAGE_W'($urandom_range(0, PAGE_MAX));
    endfunction

    // Driver: moves words onto the inputs at the falling edge, in bursts.
    always @(negedge i_clk) begin
        t_page_req rq;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !word_taken) begin
            // Word still waiting for the block; hold it.
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
            i_page_number <= any_page();
        end else if (request_q.size() > 0 &&
                     !(request_q[0].drain && grant_expect_q.size() > 0)) begin
            rq = request_q.pop_front();
            i_operation   <= rq.op;
            i_page_number <= rq.page;
            start         <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: checks result strobes and predicts each accepted word.
    always @(posedge i_clk) begin
        t_page_grant exp_g;
        t_page_req   rq;
        if (!i_rst_n) begin
            word_taken = 1'b0;
        end else begin
            if (o_done) begin
                if (grant_expect_q.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("unexpected result: page %0d status %0d",
                                 o_granted_page, o_status);
                    end
                    mismatch_count++;
                end else begin
                    exp_g = grant_expect_q.pop_front();
                    if (o_granted_page !== exp_g.page || o_status !== exp_g.status) begin
                        if (mismatch_count < 10) begin
                            $display("mismatch: page %0d (exp %0d) status %0d (exp %0d)",
                                     o_granted_page, exp_g.page, o_status, exp_g.status);
                        end
                        mismatch_count++;
                    end
                end
            end
            word_taken = start && !busy;
            if (word_taken) begin
                rq.op    = i_operation;
                rq.page  = i_page_number;
                rq.drain = 1'b0;
                grant_expect_q.push_back(predict_page_request(rq));
                words_accepted++;
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL bitmap_page_allocator");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int kind;
        int n;
        int used_hi;
        int base;
        logic [PAGE_W-1:0] pg;

        clear_page_map();

        // Directed words: low pages, page zero, extreme page numbers, the
        // unused code, double free and format.
        add_req(OP_ALLOC, '0, 1'b0);
        add_req(OP_ALLOC, '1, 1'b0);
        add_req(OP_FREE, '0, 1'b0);
        add_req(OP_ALLOC, '0, 1'b0);
        add_req(OP_ALLOC, '0, 1'b0);
        add_req(OP_FREE, '1, 1'b0);
        add_req(OP_FREE, 10'h2AA, 1'b0);
        add_req(OP_FREE, 10'h155, 1'b0);
        add_req(OP_FREE, 10'd2, 1'b0);
        add_req(OP_ALLOC, 10'h155, 1'b0);
        add_req(OP_UNUSED, '1, 1'b0);
        add_req(OP_UNUSED, '0, 1'b0);
        add_req(OP_FORMAT, '0, 1'b1);
        add_req(OP_ALLOC, '0, 1'b0);
        add_req(OP_FREE, 10'd1, 1'b0);
        add_req(OP_FREE, 10'd1, 1'b0);
        add_req(OP_ALLOC, '0, 1'b0);
        add_req(OP_FORMAT, '1, 1'b0);
        add_req(OP_ALLOC, '1, 1'b1);

        // Fill the first two bitmap words and spill into the third, free eight pages
        // picked at random anywhere, allocate ten more, then start afresh.
        add_req(OP_FORMAT, any_page(), 1'b1);
        for (int i = 0; i < 2 * WORD_W + 6; i++) begin
            add_req(OP_ALLOC, any_page(), 1'b0);
        end
        for (int i = 0; i < 8; i++) begin
            add_req(OP_FREE, any_page(), 1'b0);
        end
        for (int i = 0; i < 10; i++) begin
            add_req(OP_ALLOC, any_page(), 1'b0);
        end
        add_req(OP_FORMAT, any_page(), 1'b1);

        // Random sequences: mostly allocation runs and frees of pages likely
        // to be in use, with some noise and an occasional format.
        used_hi = 1;
        base = stim_count;
        while (stim_count < base + RANDOM_WORDS) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                n = $urandom_range(1, 40);
                for (int i = 0; i < n; i++) begin
                    add_req(OP_ALLOC, any_page(), 1'b0);
                end
                used_hi = (used_hi + n > PAGE_MAX) ? PAGE_MAX : used_hi + n;
            end else if (kind < 60) begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    pg = ($urandom_range(0, 3) == 0) ? any_page()
                                                     : PAGE_W'($urandom_range(0, used_hi));
                    add_req(OP_FREE, pg, 1'b0);
                end
            end else if (kind < 75) begin
                add_req(OP_FREE, PAGE_W'($urandom_range(0, used_hi)), 1'b0);
                add_req(OP_ALLOC, any_page(), 1'b0);
            end else if (kind < 90) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    add_req(OP_W'($urandom_range(0, 3)), any_page(), 1'b0);
                end
            end else if (kind < 95) begin
                add_req(OP_FORMAT, any_page(), 1'b0);
                used_hi = 1;
            end else begin
                // Let the block drain completely before this word.
                add_req(OP_W'($urandom_range(0, 2)), any_page(), 1'b1);
            end
        end
        words_queued = request_q.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_accepted != words_queued) begin
            @(negedge i_clk);
        end
        while (grant_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS bitmap_page_allocator");
        end else begin
            $display("FAIL bitmap_page_allocator");
        end
        $finish;
    end

endmodule
